FILE: sv/sspm_pkg.sv
// Shared types and constants for the sphere set point membership block.
package sspm_pkg;

    typedef logic [1:0] kind_t;

    localparam kind_t KIND_CLEAR = 2'd0;
    localparam kind_t KIND_LOAD  = 2'd1;
    localparam kind_t KIND_QUERY = 2'd2;

    localparam int RADIUS_BITS = 22;
    localparam int TOTAL_BITS  = 7;
    localparam int SQ_BITS     = 2 * RADIUS_BITS;
    localparam int SUM_BITS    = SQ_BITS + 2;

endpackage

FILE: sv/sspm_if.sv
// Handshake channels for request items and response items.
interface sspm_req_if #(
    parameter int COORD_BITS = 24
);
    logic                                valid;
    logic                                ready;
    sspm_pkg::kind_t                     kind;
    logic signed [COORD_BITS-1:0]        coord_x;
    logic signed [COORD_BITS-1:0]        coord_y;
    logic signed [COORD_BITS-1:0]        coord_z;
    logic [sspm_pkg::RADIUS_BITS-1:0]    sphere_radius_in;

    modport source (
        output valid, kind, coord_x, coord_y, coord_z, sphere_radius_in,
        input  ready
    );
    modport sink (
        input  valid, kind, coord_x, coord_y, coord_z, sphere_radius_in,
        output ready
    );
endinterface

interface sspm_rsp_if;
    logic                              valid;
    logic                              ready;
    logic                              inside_res;
    logic                              status;
    logic [sspm_pkg::TOTAL_BITS-1:0]   sphere_total;

    modport source (
        output valid, inside_res, status, sphere_total,
        input  ready
    );
    modport sink (
        input  valid, inside_res, status, sphere_total,
        output ready
    );
endinterface

FILE: sv/sphere_set_point_membership.sv
// Point membership test against a table of spheres with a bounding box.
//
//   channel   direction  fields
//   request   in         kind, coord_x, coord_y, coord_z, sphere_radius_in
//   response  out        inside_res, status, sphere_total
//
// A clear, a load, an unused kind, and a query that falls outside the box or meets
// an empty table skip the scan. Any other query scans the stored entries through
// the single read port of the sphere memory, one entry per cycle, into a compare
// pipeline.
// Reset empties the table and the box; no clearing pass is needed.
// The response register lets the next item be taken while a result waits.
module sphere_set_point_membership #(
    parameter int MAX_SPHERES = 64,
    parameter int COORD_BITS  = 24
) (
    input  logic          clk,
    input  logic          rst_n,
    sspm_req_if.sink      request,
    sspm_rsp_if.source    response
);

    localparam int RB       = sspm_pkg::RADIUS_BITS;
    localparam int IDX_W    = (MAX_SPHERES > 1) ? $clog2(MAX_SPHERES) : 1;
    localparam int CNT_W    = $clog2(MAX_SPHERES + 1);
    localparam int BOX_BITS = ((COORD_BITS > RB + 1) ? COORD_BITS : RB + 1) + 1;
    localparam int CMP_W    = (COORD_BITS + 1 > RB) ? COORD_BITS + 1 : RB;
    localparam int MEM_W    = 3 * COORD_BITS + RB;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SCAN = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]                 state_reg;
    logic [CNT_W-1:0]           stored_count_reg;
    logic [CNT_W-1:0]           scan_idx_reg;
    logic                       box_empty_reg;
    logic signed [BOX_BITS-1:0] box_low_x_reg, box_low_y_reg, box_low_z_reg;
    logic signed [BOX_BITS-1:0] box_high_x_reg, box_high_y_reg, box_high_z_reg;
    logic signed [COORD_BITS-1:0] q_x_reg, q_y_reg, q_z_reg;
    logic                       hit_reg;
    logic                       pend_inside_reg;
    logic                       pend_status_reg;

    logic                       out_valid_reg;
    logic                       out_inside_reg;
    logic                       out_status_reg;
    logic [sspm_pkg::TOTAL_BITS-1:0] out_total_reg;

    logic [MEM_W-1:0]           sphere_mem [MAX_SPHERES];
    logic [MEM_W-1:0]           rd_data_reg;
    logic                       rd_v_reg;

    logic                       b_v_reg;
    logic                       b_near_reg;
    logic [RB-1:0]              b_dx_reg, b_dy_reg, b_dz_reg, b_rad_reg;

    logic                       c_v_reg;
    logic                       c_near_reg;
    logic [sspm_pkg::SQ_BITS-1:0] c_sx_reg, c_sy_reg, c_sz_reg, c_rsq_reg;

    logic                       accept;
    logic                       table_full;
    logic                       do_write;
    logic                       issue;
    logic                       scan_done;
    logic                       out_free;
    logic                       out_load;

    logic signed [BOX_BITS-1:0] ext_x, ext_y, ext_z;
    logic signed [BOX_BITS-1:0] rad_ext;
    logic signed [BOX_BITS-1:0] lo_x, lo_y, lo_z, hi_x, hi_y, hi_z;
    logic                       in_box;

    logic signed [COORD_BITS-1:0] m_cx, m_cy, m_cz;
    logic [RB-1:0]              m_rad;
    logic signed [COORD_BITS:0] diff_x, diff_y, diff_z;
    logic [COORD_BITS:0]        abs_x, abs_y, abs_z;
    logic                       near;

    logic [sspm_pkg::SUM_BITS-1:0] dist_sum;
    logic                       hit_now;

    assign accept     = request.valid && request.ready;
    assign table_full = (stored_count_reg == CNT_W'(MAX_SPHERES));
    assign do_write   = accept && (request.kind == sspm_pkg::KIND_LOAD) && !table_full;
    assign issue      = (state_reg == ST_SCAN) && (scan_idx_reg != stored_count_reg);
    assign scan_done  = !issue && !rd_v_reg && !b_v_reg && !c_v_reg;
    assign out_free   = !out_valid_reg || response.ready;
    assign out_load   = (state_reg == ST_DONE) && out_free;

    assign request.ready       = (state_reg == ST_IDLE);
    assign response.valid      = out_valid_reg;
    assign response.inside_res = out_inside_reg;
    assign response.status     = out_status_reg;
    assign response.sphere_total = out_total_reg;

    // Box extents of the incoming sphere and the inclusive box test of a point.
    always_comb
    begin
        ext_x   = BOX_BITS'(request.coord_x);
        ext_y   = BOX_BITS'(request.coord_y);
        ext_z   = BOX_BITS'(request.coord_z);
        rad_ext = signed'(BOX_BITS'(request.sphere_radius_in));
        lo_x    = ext_x - rad_ext;
        lo_y    = ext_y - rad_ext;
        lo_z    = ext_z - rad_ext;
        hi_x    = ext_x + rad_ext;
        hi_y    = ext_y + rad_ext;
        hi_z    = ext_z + rad_ext;
        in_box  = !box_empty_reg && (stored_count_reg != '0) &&
                  (ext_x >= box_low_x_reg) && (ext_x <= box_high_x_reg) &&
                  (ext_y >= box_low_y_reg) && (ext_y <= box_high_y_reg) &&
                  (ext_z >= box_low_z_reg) && (ext_z <= box_high_z_reg);
    end

    // Per-axis distances against the entry just read.
    always_comb
    begin
        m_cx   = rd_data_reg[MEM_W-1 -: COORD_BITS];
        m_cy   = rd_data_reg[MEM_W-COORD_BITS-1 -: COORD_BITS];
        m_cz   = rd_data_reg[RB +: COORD_BITS];
        m_rad  = rd_data_reg[RB-1:0];
        diff_x = (COORD_BITS+1)'(q_x_reg) - (COORD_BITS+1)'(m_cx);
        diff_y = (COORD_BITS+1)'(q_y_reg) - (COORD_BITS+1)'(m_cy);
        diff_z = (COORD_BITS+1)'(q_z_reg) - (COORD_BITS+1)'(m_cz);
        abs_x  = diff_x[COORD_BITS] ? (COORD_BITS+1)'(-diff_x) : unsigned'(diff_x);
        abs_y  = diff_y[COORD_BITS] ? (COORD_BITS+1)'(-diff_y) : unsigned'(diff_y);
        abs_z  = diff_z[COORD_BITS] ? (COORD_BITS+1)'(-diff_z) : unsigned'(diff_z);
        // Any axis at or beyond the radius already fails the strict test.
        near   = (CMP_W'(abs_x) < CMP_W'(m_rad)) &&
                 (CMP_W'(abs_y) < CMP_W'(m_rad)) &&
                 (CMP_W'(abs_z) < CMP_W'(m_rad));
    end

    always_comb
    begin
        dist_sum = sspm_pkg::SUM_BITS'(c_sx_reg) + sspm_pkg::SUM_BITS'(c_sy_reg) +
                   sspm_pkg::SUM_BITS'(c_sz_reg);
        hit_now  = c_v_reg && c_near_reg &&
                   (dist_sum < sspm_pkg::SUM_BITS'(c_rsq_reg));
    end

    // Sphere memory: one write port for loads, one registered read port for scans.
    always_ff @(posedge clk)
    begin
        if (do_write)
        begin
            sphere_mem[stored_count_reg[IDX_W-1:0]] <=
                {request.coord_x, request.coord_y, request.coord_z,
                 request.sphere_radius_in};
        end
        rd_data_reg <= sphere_mem[scan_idx_reg[IDX_W-1:0]];
    end

    // Compare pipeline payload.
    always_ff @(posedge clk)
    begin
        b_near_reg <= near;
        b_dx_reg   <= RB'(abs_x);
        b_dy_reg   <= RB'(abs_y);
        b_dz_reg   <= RB'(abs_z);
        b_rad_reg  <= m_rad;
        c_near_reg <= b_near_reg;
        c_sx_reg   <= b_dx_reg * b_dx_reg;
        c_sy_reg   <= b_dy_reg * b_dy_reg;
        c_sz_reg   <= b_dz_reg * b_dz_reg;
        c_rsq_reg  <= b_rad_reg * b_rad_reg;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            q_x_reg <= request.coord_x;
            q_y_reg <= request.coord_y;
            q_z_reg <= request.coord_z;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            stored_count_reg <= '0;
            scan_idx_reg     <= '0;
            box_empty_reg    <= 1'b1;
            box_low_x_reg    <= '0;
            box_low_y_reg    <= '0;
            box_low_z_reg    <= '0;
            box_high_x_reg   <= '0;
            box_high_y_reg   <= '0;
            box_high_z_reg   <= '0;
            hit_reg          <= 1'b0;
            pend_inside_reg  <= 1'b0;
            pend_status_reg  <= 1'b0;
            out_valid_reg    <= 1'b0;
            out_inside_reg   <= 1'b0;
            out_status_reg   <= 1'b0;
            out_total_reg    <= '0;
            rd_v_reg         <= 1'b0;
            b_v_reg          <= 1'b0;
            c_v_reg          <= 1'b0;
        end
        else
        begin
            rd_v_reg <= issue;
            b_v_reg  <= rd_v_reg;
            c_v_reg  <= b_v_reg;

            if (out_load)
            begin
                out_valid_reg  <= 1'b1;
                out_inside_reg <= pend_inside_reg;
                out_status_reg <= pend_status_reg;
                out_total_reg  <= sspm_pkg::TOTAL_BITS'(stored_count_reg);
            end
            else if (out_valid_reg && response.ready)
            begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        pend_inside_reg <= 1'b0;
                        pend_status_reg <= (request.kind == sspm_pkg::KIND_LOAD) &&
                                           table_full;
                        hit_reg         <= 1'b0;
                        scan_idx_reg    <= '0;
                        state_reg       <= ((request.kind == sspm_pkg::KIND_QUERY) && in_box)
                                           ? ST_SCAN : ST_DONE;
                        case (request.kind)
                            sspm_pkg::KIND_CLEAR:
                            begin
                                stored_count_reg <= '0;
                                box_empty_reg    <= 1'b1;
                                box_low_x_reg    <= '0;
                                box_low_y_reg    <= '0;
                                box_low_z_reg    <= '0;
                                box_high_x_reg   <= '0;
                                box_high_y_reg   <= '0;
                                box_high_z_reg   <= '0;
                            end
                            sspm_pkg::KIND_LOAD:
                            begin
                                if (!table_full)
                                begin
                                    stored_count_reg <= stored_count_reg + 1'b1;
                                    box_empty_reg    <= 1'b0;
                                    if (box_empty_reg || lo_x < box_low_x_reg)
                                        box_low_x_reg <= lo_x;
                                    if (box_empty_reg || lo_y < box_low_y_reg)
                                        box_low_y_reg <= lo_y;
                                    if (box_empty_reg || lo_z < box_low_z_reg)
                                        box_low_z_reg <= lo_z;
                                    if (box_empty_reg || hi_x > box_high_x_reg)
                                        box_high_x_reg <= hi_x;
                                    if (box_empty_reg || hi_y > box_high_y_reg)
                                        box_high_y_reg <= hi_y;
                                    if (box_empty_reg || hi_z > box_high_z_reg)
                                        box_high_z_reg <= hi_z;
                                end
                            end
                            default:
                            begin
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    if (issue)
                    begin
                        scan_idx_reg <= scan_idx_reg + 1'b1;
                    end
                    if (hit_now)
                    begin
                        hit_reg <= 1'b1;
                    end
                    if (scan_done)
                    begin
                        pend_inside_reg <= hit_reg;
                        state_reg       <= ST_DONE;
                    end
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule

FILE: sim/sphere_set_point_membership_tb.sv
// Self-checking testbench for the sphere set point membership block.
module sphere_set_point_membership_tb;

    localparam int COORD_W        = 24;
    localparam int MAX_SPHERES    = 64;
    localparam int HOLD_CYCLES    = 400;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int DRAIN_CYCLES   = 100;

    // The package names three kinds; the fourth code changes nothing but still gets a response.
    localparam sspm_pkg::kind_t KIND_UNUSED = 2'd3;

    typedef logic signed [COORD_W-1:0]             coord_t;
    typedef logic [sspm_pkg::RADIUS_BITS-1:0]      radius_t;

    localparam coord_t  COORD_MAX  = 24'sh7FFFFF;
    localparam coord_t  COORD_MIN  = 24'sh800000;
    localparam radius_t RADIUS_MAX = '1;

    typedef struct packed {
        logic                            hit;
        logic                            status;
        logic [sspm_pkg::TOTAL_BITS-1:0] total;
    } membership_t;

    logic clk = 1'b0;
    logic rst_n;

    always #6 clk = ~clk;

    sspm_req_if #(.COORD_BITS(COORD_W)) req_ch ();
    sspm_rsp_if                         rsp_ch ();

    sphere_set_point_membership #(
        .MAX_SPHERES(MAX_SPHERES),
        .COORD_BITS (COORD_W)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (req_ch),
        .response(rsp_ch)
    );

    // Predicted contents of the sphere table and bounding box.
    coord_t  tbl_ctr [MAX_SPHERES][3];
    radius_t tbl_rad [MAX_SPHERES];
    int      tbl_count;
    bit      box_none;
    longint  box_lo [3];
    longint  box_hi [3];

    membership_t expected_answers[$];

    bit feed_gaps;
    bit sink_gaps;
    bit hold_request;
    int mismatch_count;
    int items_sent;
    int clears_seen, loads_stored, loads_dropped, queries_seen, query_hits;

    function automatic membership_t predict_membership(input sspm_pkg::kind_t k,
                                                       input coord_t x,
                                                       input coord_t y, input coord_t z,
                                                       input radius_t r);
        membership_t res;
        longint      p [3];
        longint      rad;
        longint      d;
        longint      sum;
        bit          in_box;
        bit          near;
        res  = '0;
        p[0] = x;
        p[1] = y;
        p[2] = z;
        case (k)
            sspm_pkg::KIND_CLEAR: begin
                clears_seen++;
                tbl_count = 0;
                box_none  = 1'b1;
                for (int a = 0; a < 3; a++) begin
                    box_lo[a] = 0;
                    box_hi[a] = 0;
                end
            end
            sspm_pkg::KIND_LOAD: begin
                if (tbl_count >= MAX_SPHERES) begin
                    res.status = 1'b1;
                    loads_dropped++;
                end else begin
                    rad = r;
                    for (int a = 0; a < 3; a++) begin
                        tbl_ctr[tbl_count][a] = coord_t'(p[a]);
                        if (box_none || p[a] - rad < box_lo[a])
                            box_lo[a] = p[a] - rad;
                        if (box_none || p[a] + rad > box_hi[a])
                            box_hi[a] = p[a] + rad;
                    end
                    tbl_rad[tbl_count] = r;
                    tbl_count++;
                    box_none = 1'b0;
                    loads_stored++;
                end
            end
            sspm_pkg::KIND_QUERY: begin
                queries_seen++;
                in_box = !box_none && tbl_count > 0;
                for (int a = 0; a < 3; a++)
                    if (p[a] < box_lo[a] || p[a] > box_hi[a])
                        in_box = 1'b0;
                if (in_box) begin
                    for (int i = 0; i < tbl_count && !res.hit; i++) begin
                        rad  = tbl_rad[i];
                        sum  = 0;
                        near = 1'b1;
                        for (int a = 0; a < 3; a++) begin
                            d = p[a] - longint'(tbl_ctr[i][a]);
                            if (d < 0)
                                d = -d;
                            if (d >= rad)
                                near = 1'b0;
                            sum += d * d;
                        end
                        if (near && sum < rad * rad)
                            res.hit = 1'b1;
                    end
                end
                if (res.hit)
                    query_hits++;
            end
            default: ;
        endcase
        res.total = tbl_count[sspm_pkg::TOTAL_BITS-1:0];
        return res;
    endfunction

    // Called just after a falling edge; returns just after the falling edge that follows
    // acceptance, with valid still high, so back-to-back items keep the channel busy.
    task automatic send_item(input sspm_pkg::kind_t k, input coord_t x, input coord_t y,
                             input coord_t z, input radius_t r);
        int gap;
        if (feed_gaps && $urandom_range(0, 4) == 0) begin
            gap = $urandom_range(1, 19);
            req_ch.valid = 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_ch.kind             = k;
        req_ch.coord_x          = x;
        req_ch.coord_y          = y;
        req_ch.coord_z          = z;
        req_ch.sphere_radius_in = r;
        req_ch.valid            = 1'b1;
        do
            @(posedge clk);
        while (req_ch.ready !== 1'b1);
        expected_answers.push_back(predict_membership(k, x, y, z, r));
        if (k != KIND_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_all_answered();
        req_ch.valid = 1'b0;
        while (expected_answers.size() != 0)
            @(negedge clk);
    endtask

    // Small style keeps spheres near the origin so that they overlap and queries hit.
    task automatic make_sphere(input int style, output coord_t x, output coord_t y,
                               output coord_t z, output radius_t r);
        if (style == 1) begin
            x = coord_t'($urandom_range(0, 8000) - 4000);
            y = coord_t'($urandom_range(0, 8000) - 4000);
            z = coord_t'($urandom_range(0, 8000) - 4000);
            r = radius_t'($urandom_range(0, 3000));
        end else begin
            x = coord_t'($urandom);
            y = coord_t'($urandom);
            z = coord_t'($urandom);
            r = (style == 0 && $urandom_range(0, 2) != 0) ? radius_t'($urandom_range(0, 5000))
                                                           : radius_t'($urandom);
        end
    endtask

    task automatic make_query_point(input int style, output coord_t x, output coord_t y,
                                    output coord_t z);
        int     idx;
        int     axis;
        longint rad;
        longint off;
        longint p [3];
        if (tbl_count == 0 || $urandom_range(0, 4) == 0) begin
            if (style == 1) begin
                p[0] = longint'($urandom_range(0, 16000)) - 8000;
                p[1] = longint'($urandom_range(0, 16000)) - 8000;
                p[2] = longint'($urandom_range(0, 16000)) - 8000;
            end else begin
                p[0] = $urandom;
                p[1] = $urandom;
                p[2] = $urandom;
            end
        end else begin
            idx = $urandom_range(0, tbl_count - 1);
            rad = tbl_rad[idx];
            for (int a = 0; a < 3; a++)
                p[a] = tbl_ctr[idx][a];
            if ($urandom_range(0, 5) == 0) begin
                // A point on the surface along one axis: inside the box, outside the sphere.
                axis = $urandom_range(0, 2);
                p[axis] += ($urandom_range(0, 1) != 0) ? rad : -rad;
            end else begin
                for (int a = 0; a < 3; a++) begin
                    off = longint'($urandom_range(0, int'(2 * rad + 4))) - (rad + 2);
                    p[a] += off;
                end
            end
        end
        x = coord_t'(p[0]);
        y = coord_t'(p[1]);
        z = coord_t'(p[2]);
    endtask

    task automatic run_session(input bit allow_gaps);
        int      n_load;
        int      n_query;
        int      style;
        int      mode;
        coord_t  x, y, z;
        radius_t r;
        if (allow_gaps) begin
            mode      = $urandom_range(0, 3);
            feed_gaps = mode[0];
            sink_gaps = mode[1];
        end else begin
            feed_gaps = 1'b0;
            sink_gaps = 1'b0;
        end
        if ($urandom_range(0, 7) != 0)
            send_item(sspm_pkg::KIND_CLEAR, coord_t'($urandom), coord_t'($urandom),
                      coord_t'($urandom), radius_t'($urandom));
        style  = $urandom_range(0, 2);
        n_load = ($urandom_range(0, 11) == 0) ? $urandom_range(30, 70) : $urandom_range(1, 8);
        for (int i = 0; i < n_load; i++) begin
            make_sphere(style, x, y, z, r);
            send_item(sspm_pkg::KIND_LOAD, x, y, z, r);
            if ($urandom_range(0, 9) == 0) begin
                make_query_point(style, x, y, z);
                send_item(sspm_pkg::KIND_QUERY, x, y, z, radius_t'($urandom));
            end
            if ($urandom_range(0, 24) == 0)
                send_item(KIND_UNUSED, coord_t'($urandom), coord_t'($urandom),
                          coord_t'($urandom), radius_t'($urandom));
        end
        n_query = $urandom_range(3, 10);
        for (int i = 0; i < n_query; i++) begin
            make_query_point(style, x, y, z);
            send_item(sspm_pkg::KIND_QUERY, x, y, z, radius_t'($urandom));
        end
    endtask

    task automatic test_directed();
        feed_gaps = 1'b1;
        sink_gaps = 1'b1;
        send_item(sspm_pkg::KIND_QUERY, 0, 0, 0, 0);
        send_item(KIND_UNUSED, COORD_MAX, COORD_MIN, COORD_MAX, RADIUS_MAX);
        send_item(sspm_pkg::KIND_LOAD, 0, 0, 0, 100);
        send_item(sspm_pkg::KIND_QUERY, 0, 0, 0, 0);
        send_item(sspm_pkg::KIND_QUERY, 99, 0, 0, 0);
        send_item(sspm_pkg::KIND_QUERY, 0, -100, 0, 0);
        send_item(sspm_pkg::KIND_QUERY, 60, 80, 0, 0);
        send_item(sspm_pkg::KIND_QUERY, 59, 80, 0, 0);
        send_item(sspm_pkg::KIND_QUERY, 0, 0, 101, 0);
        // A zero radius still grows the box but never contains its own center.
        send_item(sspm_pkg::KIND_LOAD, 1000, 1000, 1000, 0);
        send_item(sspm_pkg::KIND_QUERY, 1000, 1000, 1000, 0);
        send_item(sspm_pkg::KIND_QUERY, 500, 500, 500, 0);
        send_item(sspm_pkg::KIND_LOAD, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
        send_item(sspm_pkg::KIND_LOAD, COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
        send_item(sspm_pkg::KIND_QUERY, COORD_MIN, COORD_MIN, COORD_MIN, RADIUS_MAX);
        send_item(sspm_pkg::KIND_QUERY, COORD_MAX, COORD_MIN, COORD_MAX, 0);
        send_item(sspm_pkg::KIND_QUERY, COORD_MAX, COORD_MAX, COORD_MAX - 24'sd5, 0);
        send_item(KIND_UNUSED, 0, 0, 0, 0);
        send_item(sspm_pkg::KIND_CLEAR, COORD_MAX, COORD_MAX, COORD_MAX, RADIUS_MAX);
        send_item(sspm_pkg::KIND_QUERY, 0, 0, 0, 0);
        send_item(sspm_pkg::KIND_LOAD, -5, 7, -9, 3);
        send_item(sspm_pkg::KIND_QUERY, -5, 7, -9, 0);
        send_item(sspm_pkg::KIND_QUERY, -5, 7, -12, 0);
        wait_all_answered();
    endtask

    task automatic test_table_full();
        coord_t  x, y, z;
        radius_t r;
        feed_gaps = 1'b1;
        sink_gaps = 1'b1;
        send_item(sspm_pkg::KIND_CLEAR, 0, 0, 0, 0);
        for (int i = 0; i < MAX_SPHERES; i++) begin
            make_sphere(1, x, y, z, r);
            send_item(sspm_pkg::KIND_LOAD, x, y, z, r);
        end
        for (int i = 0; i < 3; i++) begin
            make_sphere(2, x, y, z, r);
            send_item(sspm_pkg::KIND_LOAD, x, y, z, r);
        end
        for (int i = 0; i < 6; i++) begin
            make_query_point(1, x, y, z);
            send_item(sspm_pkg::KIND_QUERY, x, y, z, 0);
        end
        send_item(KIND_UNUSED, 0, 0, 0, 0);
        wait_all_answered();
    endtask

    // The receiver stops for a long stretch while items keep coming, so the
    // block has to hold its input off.
    task automatic test_input_backpressure();
        coord_t  x, y, z;
        radius_t r;
        feed_gaps = 1'b0;
        sink_gaps = 1'b0;
        send_item(sspm_pkg::KIND_CLEAR, 0, 0, 0, 0);
        hold_request = 1'b1;
        for (int i = 0; i < 16; i++) begin
            if (i % 3 == 2) begin
                make_query_point(1, x, y, z);
                send_item(sspm_pkg::KIND_QUERY, x, y, z, 0);
            end else begin
                make_sphere(1, x, y, z, r);
                send_item(sspm_pkg::KIND_LOAD, x, y, z, r);
            end
        end
        wait_all_answered();
    endtask

    task automatic test_random_traffic(input int count, input bit allow_gaps);
        int stop_at;
        stop_at = items_sent + count;
        while (items_sent < stop_at)
            run_session(allow_gaps);
        wait_all_answered();
    endtask

    // Response side: random stalls, plus one long hold-off on request.
    initial begin
        rsp_ch.ready = 1'b0;
        forever begin
            @(negedge clk);
            if (hold_request) begin
                hold_request = 1'b0;
                rsp_ch.ready = 1'b0;
                repeat (HOLD_CYCLES - 1) @(negedge clk);
            end else if (sink_gaps && $urandom_range(0, 5) == 0) begin
                rsp_ch.ready = 1'b0;
                repeat ($urandom_range(0, 18)) @(negedge clk);
            end else begin
                rsp_ch.ready = 1'b1;
            end
        end
    end

    always @(posedge clk) begin
        membership_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready) begin
            if (expected_answers.size() == 0) begin
                $display("%0t: result with no item pending: inside_res %0b status %0b total %0d",
                         $time, rsp_ch.inside_res, rsp_ch.status, rsp_ch.sphere_total);
                mismatch_count++;
            end else begin
                want = expected_answers.pop_front();
                if (rsp_ch.inside_res !== want.hit) begin
                    $display("%0t: inside_res expected %0b, got %0b",
                             $time, want.hit, rsp_ch.inside_res);
                    mismatch_count++;
                end
                if (rsp_ch.status !== want.status) begin
                    $display("%0t: status expected %0b, got %0b",
                             $time, want.status, rsp_ch.status);
                    mismatch_count++;
                end
                if (rsp_ch.sphere_total !== want.total) begin
                    $display("%0t: sphere_total expected %0d, got %0d",
                             $time, want.total, rsp_ch.sphere_total);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < WATCHDOG_LIMIT) begin
            @(posedge clk);
            if (!rst_n || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("%0t: no progress for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

    initial begin
        rst_n                   = 1'b0;
        req_ch.valid            = 1'b0;
        req_ch.kind             = sspm_pkg::KIND_CLEAR;
        req_ch.coord_x          = '0;
        req_ch.coord_y          = '0;
        req_ch.coord_z          = '0;
        req_ch.sphere_radius_in = '0;
        feed_gaps               = 1'b0;
        sink_gaps               = 1'b0;
        hold_request            = 1'b0;
        mismatch_count          = 0;
        items_sent              = 0;
        tbl_count               = 0;
        box_none                = 1'b1;
        for (int a = 0; a < 3; a++) begin
            box_lo[a] = 0;
            box_hi[a] = 0;
        end
        repeat (7) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_table_full();
        test_input_backpressure();
        test_random_traffic(280, 1'b1);
        test_random_traffic(50, 1'b0);

        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Sent %0d items: %0d clears, %0d loads stored, %0d loads refused on a full table,",
                 items_sent, clears_seen, loads_stored, loads_dropped);
        $display("and %0d point queries of which %0d fell inside a sphere.",
                 queries_seen, query_hits);
        if (mismatch_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
